[sv/rga_pkg.sv]
package rga_pkg;

    localparam int MAX_NODES_DEF  = 64;
    localparam int COORD_BITS_DEF = 24;
    localparam int TOL_BITS       = 8;
    localparam int PEER_BITS      = 7;
    localparam int OUT_IDX_BITS   = 6;

    localparam logic [TOL_BITS-1:0]  TOL_RESET = 8'd16;
    localparam logic [PEER_BITS-1:0] PEER_NONE = 7'h7F;

    localparam logic [1:0] KIND_RECT  = 2'd0;
    localparam logic [1:0] KIND_LINE  = 2'd1;
    localparam logic [1:0] KIND_OTHER = 2'd2;
    // unused encoding, handled like an other shape
    localparam logic [1:0] KIND_SPARE = 2'd3;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_WRITE,
        S_NODE_RD,
        S_NODE_LD,
        S_EMIT
    } t_state;

endpackage

[sv/rga_ram.sv]
module rga_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[sv/rect_group_assigner.sv]
// Load: a valid rect reads every stored entry through the compare pipe,
// then writes itself; any other node is written directly, and a node that
// finds the batch full is dropped. Emission after the last node: each node
// is read back, loaded and emitted, and a valid non-rect node first scans all
// stored entries (one read port) for the smallest matching rect.
// Results come one per strobe cycle and cannot be stalled. Synchronous
// active-low reset empties the batch and sets the tolerance to 16.
module rect_group_assigner
    import rga_pkg::*;
#(
    parameter int MAX_NODES  = MAX_NODES_DEF,
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [1:0]                   i_node_kind,
    input  logic                         i_box_valid,
    input  logic signed [COORD_BITS-1:0] i_left_x,
    input  logic signed [COORD_BITS-1:0] i_bottom_y,
    input  logic signed [COORD_BITS-1:0] i_right_x,
    input  logic signed [COORD_BITS-1:0] i_top_y,
    input  logic                         i_last_node,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [TOL_BITS-1:0]          i_cfg_data,
    output logic                         o_result_strobe,
    output logic [OUT_IDX_BITS-1:0]      o_node_index,
    output logic signed [PEER_BITS-1:0]  o_group_id,
    output logic                         o_last_result
);

    localparam int CB = COORD_BITS;
    localparam int IW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
    localparam int CW = $clog2(MAX_NODES + 1);
    localparam int EW = 4 * CB + 3 + PEER_BITS;
    localparam int AWD = 2 * (CB + 1);

    t_state r_state, n_state;

    logic [CW-1:0] r_cnt, r_j;
    logic [CW-1:0] r_i;
    logic          r_mode_grp, r_last;
    logic [1:0]    r_kind;
    logic          r_valid;
    logic signed [CB-1:0] r_x0, r_y0, r_x1, r_y1;
    logic [TOL_BITS-1:0]  r_tol;

    logic                 r_v1, r_v2;
    logic signed [AWD-1:0] r_area2, r_min_area;
    logic [PEER_BITS-1:0]  r_peer2, r_best_peer;
    logic                  r_found;
    logic [PEER_BITS-1:0]  r_res;

    logic [EW-1:0] rd, wdata;
    logic [IW-1:0] raddr;
    logic          we;

    // entry read back
    logic signed [CB-1:0] ex0, ey0, ex1, ey1;
    logic [1:0]           ekind;
    logic                 evalid;
    logic [PEER_BITS-1:0] epeer;

    assign ex0    = rd[CB-1:0];
    assign ey0    = rd[2*CB-1:CB];
    assign ex1    = rd[3*CB-1:2*CB];
    assign ey1    = rd[4*CB-1:3*CB];
    assign ekind  = rd[4*CB+1:4*CB];
    assign evalid = rd[4*CB+2];
    assign epeer  = rd[EW-1:4*CB+3];

    logic [PEER_BITS-1:0] wpeer;
    always_comb begin
        if (r_kind == KIND_RECT && r_valid) begin
            wpeer = r_found ? r_best_peer : PEER_BITS'(r_cnt);
        end else begin
            wpeer = PEER_NONE;
        end
    end
    assign wdata = {wpeer, r_valid, r_kind, r_y1, r_x1, r_y0, r_x0};
    assign we    = (r_state == S_WRITE);
    assign raddr = (r_state == S_SCAN) ? r_j[IW-1:0] : r_i[IW-1:0];

    rga_ram #(.WIDTH(EW), .DEPTH(MAX_NODES), .AW(IW)) u_ram (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(r_cnt[IW-1:0]),
        .i_wdata(wdata),
        .i_raddr(raddr),
        .o_rdata(rd)
    );

    // stage 1: compare entry against current node
    logic signed [CB+1:0] d0, d1, d2, d3, tol_p, tol_n;
    logic signed [CB:0]   cx2, cy2, ax0, ax1, ay0, ay1, dx, dy;
    logic                 t_near, t_line, t_ctr, hit1;
    logic signed [AWD-1:0] area1;

    always_comb begin
        tol_p = (CB+2)'($signed({1'b0, r_tol}));
        tol_n = -tol_p;
        d0 = (CB+2)'(r_x0) - (CB+2)'(ex0);
        d1 = (CB+2)'(r_y0) - (CB+2)'(ey0);
        d2 = (CB+2)'(r_x1) - (CB+2)'(ex1);
        d3 = (CB+2)'(r_y1) - (CB+2)'(ey1);
        t_near = (d0 < tol_p) && (d0 > tol_n) && (d1 < tol_p) && (d1 > tol_n) &&
                 (d2 < tol_p) && (d2 > tol_n) && (d3 < tol_p) && (d3 > tol_n);
        t_line = !((r_x1 < ex0) || (r_x0 > ex1) || (r_y1 < ey0) || (r_y0 > ey1));
        cx2 = (CB+1)'(r_x0) + (CB+1)'(r_x1);
        cy2 = (CB+1)'(r_y0) + (CB+1)'(r_y1);
        ax0 = {ex0, 1'b0};
        ax1 = {ex1, 1'b0};
        ay0 = {ey0, 1'b0};
        ay1 = {ey1, 1'b0};
        t_ctr = (cx2 >= ax0) && (cx2 <= ax1) && (cy2 >= ay0) && (cy2 <= ay1);
        dx = (CB+1)'(ex1) - (CB+1)'(ex0);
        dy = (CB+1)'(ey1) - (CB+1)'(ey0);
        area1 = AWD'(dx) * AWD'(dy);
        if (!r_mode_grp) begin
            hit1 = t_near;
        end else if (r_kind == KIND_LINE) begin
            hit1 = t_line;
        end else begin
            hit1 = t_ctr;
        end
        hit1 = hit1 && r_v1 && ekind == KIND_RECT && evalid;
    end

    logic scan_done;
    assign scan_done = (r_j == r_cnt) && !r_v1 && !r_v2;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    if (r_cnt < CW'(MAX_NODES)) begin
                        n_state = (i_node_kind == KIND_RECT && i_box_valid) ? S_SCAN : S_WRITE;
                    end else if (i_last_node && r_cnt != '0) begin
                        n_state = S_NODE_RD;
                    end
                end
            end
            S_SCAN: begin
                if (scan_done) begin
                    n_state = r_mode_grp ? S_EMIT : S_WRITE;
                end
            end
            S_WRITE:   n_state = r_last ? S_NODE_RD : S_IDLE;
            S_NODE_RD: n_state = S_NODE_LD;
            S_NODE_LD: begin
                n_state = (ekind != KIND_RECT && evalid) ? S_SCAN : S_EMIT;
            end
            S_EMIT: begin
                n_state = (r_i == r_cnt - 1'b1) ? S_IDLE : S_NODE_RD;
            end
            default:   n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_tol   <= TOL_RESET;
            r_v1    <= 1'b0;
            r_v2    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) begin
                r_tol <= i_cfg_data;
            end
            r_v1 <= (r_state == S_SCAN) && (r_j != r_cnt);
            r_v2 <= hit1;
            if (r_state == S_WRITE) begin
                r_cnt <= r_cnt + 1'b1;
            end
            if (r_state == S_EMIT && n_state == S_IDLE) begin
                r_cnt <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_area2 <= area1;
        r_peer2 <= epeer;
        if (r_state == S_SCAN && r_j != r_cnt) begin
            r_j <= r_j + 1'b1;
        end
        // stage 2: first match on load, smallest area when grouping
        if (r_v2 && (!r_found || (r_mode_grp && r_area2 < r_min_area))) begin
            r_found     <= 1'b1;
            r_min_area  <= r_area2;
            r_best_peer <= r_peer2;
        end
        case (r_state)
            S_IDLE: begin
                r_j     <= '0;
                r_found <= 1'b0;
                r_i     <= '0;
                if (start) begin
                    r_mode_grp <= 1'b0;
                    r_last     <= i_last_node;
                    r_kind     <= i_node_kind;
                    r_valid    <= i_box_valid;
                    r_x0       <= i_left_x;
                    r_y0       <= i_bottom_y;
                    r_x1       <= i_right_x;
                    r_y1       <= i_top_y;
                end
            end
            S_SCAN: begin
                if (scan_done) begin
                    r_res <= r_found ? r_best_peer : PEER_NONE;
                end
            end
            S_NODE_RD: begin
                r_j     <= '0;
                r_found <= 1'b0;
            end
            S_NODE_LD: begin
                r_mode_grp <= 1'b1;
                r_kind     <= ekind;
                r_valid    <= evalid;
                r_x0       <= ex0;
                r_y0       <= ey0;
                r_x1       <= ex1;
                r_y1       <= ey1;
                if (ekind == KIND_RECT && evalid) begin
                    r_res <= epeer;
                end else begin
                    r_res <= PEER_NONE;
                end
            end
            S_EMIT: begin
                r_i <= r_i + 1'b1;
            end
            default: begin
            end
        endcase
    end

    assign busy            = (r_state != S_IDLE);
    assign o_cfg_ready     = 1'b1;
    assign o_result_strobe = (r_state == S_EMIT);
    assign o_node_index    = OUT_IDX_BITS'(r_i);
    assign o_group_id      = r_res;
    assign o_last_result   = (r_i == r_cnt - 1'b1);

endmodule

[sim/rect_group_checker.sv]
`timescale 1ns / 1ps

module rect_group_checker
    import rga_pkg::*;
(
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    input  logic                         busy,
    input  logic [1:0]                   i_node_kind,
    input  logic                         i_box_valid,
    input  logic signed [23:0]           i_left_x,
    input  logic signed [23:0]           i_bottom_y,
    input  logic signed [23:0]           i_right_x,
    input  logic signed [23:0]           i_top_y,
    input  logic                         i_last_node,
    input  logic                         i_cfg_valid,
    input  logic                         o_cfg_ready,
    input  logic [TOL_BITS-1:0]          i_cfg_data,
    input  logic                         o_result_strobe,
    input  logic [OUT_IDX_BITS-1:0]      o_node_index,
    input  logic signed [PEER_BITS-1:0]  o_group_id,
    input  logic                         o_last_result,
    output int                           o_fail_count,
    output int                           o_pending,
    output int                           o_result_count
);

    typedef struct {
        logic [OUT_IDX_BITS-1:0]     idx;
        logic signed [PEER_BITS-1:0] gid;
        logic                        last;
    } t_group_result;

    longint      node_x0 [MAX_NODES_DEF];
    longint      node_x1 [MAX_NODES_DEF];
    longint      node_y0 [MAX_NODES_DEF];
    longint      node_y1 [MAX_NODES_DEF];
    logic [1:0]  node_kind [MAX_NODES_DEF];
    logic        node_ok [MAX_NODES_DEF];
    int          node_peer [MAX_NODES_DEF];
    int          n_stored;
    int          tolerance;
    int          fails;
    int          results;
    t_group_result group_q[$];

    function automatic bit valid_rect(int j);
        return node_kind[j] == KIND_RECT && node_ok[j];
    endfunction

    function automatic bit near(longint a, longint b);
        longint d;
        d = a - b;
        if (d < 0) d = -d;
        return d < tolerance;
    endfunction

    function automatic int group_of(int i);
        int     best;
        longint min_area;
        longint ar;
        bit     hit;
        best = -1;
        min_area = 0;
        if (node_kind[i] == KIND_RECT) return node_ok[i] ? node_peer[i] : -1;
        if (!node_ok[i]) return -1;
        for (int j = 0; j < n_stored; j++) begin
            if (j == i || !valid_rect(j)) continue;
            if (node_kind[i] == KIND_LINE)
                hit = !(node_x1[i] < node_x0[j] || node_x0[i] > node_x1[j] ||
                        node_y1[i] < node_y0[j] || node_y0[i] > node_y1[j]);
            else
                // center test on doubled coordinates; the spare kind lands here too
                hit = (node_x0[i] + node_x1[i]) >= 2 * node_x0[j] &&
                      (node_x0[i] + node_x1[i]) <= 2 * node_x1[j] &&
                      (node_y0[i] + node_y1[i]) >= 2 * node_y0[j] &&
                      (node_y0[i] + node_y1[i]) <= 2 * node_y1[j];
            if (!hit) continue;
            ar = (node_x1[j] - node_x0[j]) * (node_y1[j] - node_y0[j]);
            if (best < 0 || ar < min_area) begin
                min_area = ar;
                best = j;
            end
        end
        return best >= 0 ? node_peer[best] : -1;
    endfunction

    task automatic load_node();
        int k;
        k = n_stored;
        node_x0[k] = i_left_x;
        node_y0[k] = i_bottom_y;
        node_x1[k] = i_right_x;
        node_y1[k] = i_top_y;
        node_kind[k] = i_node_kind;
        node_ok[k] = i_box_valid;
        node_peer[k] = -1;
        if (i_node_kind == KIND_RECT && i_box_valid) begin
            node_peer[k] = k;
            for (int i = 0; i < k; i++) begin
                if (valid_rect(i) && near(node_x0[k], node_x0[i]) &&
                    near(node_y0[k], node_y0[i]) && near(node_x1[k], node_x1[i]) &&
                    near(node_y1[k], node_y1[i])) begin
                    node_peer[k] = node_peer[i];
                    break;
                end
            end
        end
        n_stored = k + 1;
    endtask

    task automatic emit_groups();
        t_group_result r;
        for (int i = 0; i < n_stored; i++) begin
            r.idx = i[OUT_IDX_BITS-1:0];
            r.gid = PEER_BITS'(group_of(i));
            r.last = (i + 1 == n_stored);
            group_q.push_back(r);
        end
        n_stored = 0;
    endtask

    task automatic check_result();
        t_group_result e;
        results++;
        if (group_q.size() == 0) begin
            fails++;
            if (fails <= 10)
                $display("unexpected result idx=%0d gid=%0d last=%0d",
                         o_node_index, o_group_id, o_last_result);
            return;
        end
        e = group_q.pop_front();
        if (e.idx !== o_node_index || e.gid !== o_group_id || e.last !== o_last_result) begin
            fails++;
            if (fails <= 10)
                $display("mismatch: exp idx=%0d gid=%0d last=%0d, got idx=%0d gid=%0d last=%0d",
                         e.idx, e.gid, e.last, o_node_index, o_group_id, o_last_result);
        end
    endtask

    initial begin
        fails = 0;
        results = 0;
        n_stored = 0;
        tolerance = TOL_RESET;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            n_stored = 0;
            tolerance = TOL_RESET;
            group_q.delete();
        end else begin
            if (i_cfg_valid && o_cfg_ready) tolerance = i_cfg_data;
            if (o_result_strobe) check_result();
            if (start && !busy) begin
                if (n_stored < MAX_NODES_DEF) load_node();
                // a dropped node still closes the batch
                if (i_last_node && n_stored > 0) emit_groups();
            end
        end
        o_fail_count <= fails;
        o_pending <= group_q.size();
        o_result_count <= results;
    end

endmodule

[sim/rect_group_assigner_test.sv]
`timescale 1ns / 1ps

module rect_group_assigner_test;
    import rga_pkg::*;

    logic                        i_clk;
    logic                        i_rst_n;
    logic                        start;
    logic                        busy;
    logic [1:0]                  i_node_kind;
    logic                        i_box_valid;
    logic signed [23:0]          i_left_x;
    logic signed [23:0]          i_bottom_y;
    logic signed [23:0]          i_right_x;
    logic signed [23:0]          i_top_y;
    logic                        i_last_node;
    logic                        i_cfg_valid;
    logic                        o_cfg_ready;
    logic [TOL_BITS-1:0]         i_cfg_data;
    logic                        o_result_strobe;
    logic [OUT_IDX_BITS-1:0]     o_node_index;
    logic signed [PEER_BITS-1:0] o_group_id;
    logic                        o_last_result;
    int                          fail_count;
    int                          pending;
    int                          result_count;

    int requests_sent;
    int batch_count;
    bit no_idle;
    int rect_l[4];
    int rect_b[4];
    int rect_r[4];
    int rect_t[4];

    localparam int CMIN = -8388608;
    localparam int CMAX = 8388607;

    rect_group_assigner dut (.*);

    rect_group_checker checker_i (
        .i_clk, .i_rst_n, .start, .busy, .i_node_kind, .i_box_valid,
        .i_left_x, .i_bottom_y, .i_right_x, .i_top_y, .i_last_node,
        .i_cfg_valid, .o_cfg_ready, .i_cfg_data, .o_result_strobe,
        .o_node_index, .o_group_id, .o_last_result,
        .o_fail_count(fail_count), .o_pending(pending), .o_result_count(result_count)
    );

    always begin
        i_clk = 1'b1;
        #2;
        i_clk = 1'b0;
        #2;
    end

    initial begin
        #4000000;
        $display("rect_group_assigner verification failed");
        $finish;
    end

    task automatic send_node(input logic [1:0] k, input logic v, input int lx, input int by,
                             input int rx, input int ty, input logic last);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 8);
        if (gap > 0) begin
            if (start) start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_node_kind <= k;
        i_box_valid <= v;
        i_left_x    <= 24'(lx);
        i_bottom_y  <= 24'(by);
        i_right_x   <= 24'(rx);
        i_top_y     <= 24'(ty);
        i_last_node <= last;
        start       <= 1'b1;
        do @(posedge i_clk); while (busy);
        requests_sent++;
        if (last) batch_count++;
    endtask

    // drain all results, then cover a load or scan still in flight
    task automatic wait_idle();
        start <= 1'b0;
        do @(posedge i_clk); while (pending != 0 || busy);
        repeat (80) @(posedge i_clk);
    endtask

    task automatic write_tolerance(input int v);
        i_cfg_data  <= TOL_BITS'(v);
        i_cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic int scene_coord();
        if ($urandom_range(0, 7) == 0) return $signed($urandom() << 8) >>> 8;
        return $urandom_range(0, 4000) - 2000;
    endfunction

    task automatic random_batch(input int n);
        int pick, slot, x, y, w, h, d;
        logic [1:0] k;
        for (int i = 0; i < n; i++) begin
            pick = $urandom_range(0, 99);
            slot = $urandom_range(0, 3);
            if (pick < 15) begin
                // near copy of a recent rect, edges jittered around the tolerance
                d = 20;
                send_node(KIND_RECT, 1'b1,
                          rect_l[slot] + $urandom_range(0, 2 * d) - d,
                          rect_b[slot] + $urandom_range(0, 2 * d) - d,
                          rect_r[slot] + $urandom_range(0, 2 * d) - d,
                          rect_t[slot] + $urandom_range(0, 2 * d) - d, i == n - 1);
            end else if (pick < 35) begin
                x = scene_coord();
                y = scene_coord();
                w = $urandom_range(0, 9) == 0 ? -$urandom_range(0, 300) : $urandom_range(0, 3000);
                h = $urandom_range(0, 9) == 0 ? -$urandom_range(0, 300) : $urandom_range(0, 3000);
                rect_l[slot] = x;
                rect_b[slot] = y;
                rect_r[slot] = x + w;
                rect_t[slot] = y + h;
                send_node(KIND_RECT, 1'b1, x, y, x + w, y + h, i == n - 1);
            end else if (pick < 88) begin
                // point or box placed near a recent rect
                k = pick < 60 ? KIND_LINE : KIND_OTHER;
                x = rect_l[slot] + $urandom_range(0, 400) - 100;
                y = rect_b[slot] + $urandom_range(0, 400) - 100;
                w = $urandom_range(0, 200);
                h = $urandom_range(0, 200);
                send_node(k, 1'b1, x, y, x + w, y + h, i == n - 1);
            end else begin
                k = 2'($urandom_range(0, 3));
                send_node(k, 1'($urandom_range(0, 1)), scene_coord(), scene_coord(),
                          scene_coord(), scene_coord(), i == n - 1);
            end
        end
    endtask

    initial begin
        requests_sent = 0;
        batch_count = 0;
        no_idle = 1'b0;
        start = 1'b0;
        i_node_kind = KIND_RECT;
        i_box_valid = 1'b0;
        i_left_x = '0;
        i_bottom_y = '0;
        i_right_x = '0;
        i_top_y = '0;
        i_last_node = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_data = '0;
        foreach (rect_l[i]) begin
            rect_l[i] = 0;
            rect_b[i] = 0;
            rect_r[i] = 1000;
            rect_t[i] = 1000;
        end
        i_rst_n = 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // default tolerance: peer matching on both sides of the strict limit
        send_node(KIND_RECT, 1'b1, 0, 0, 1600, 1600, 1'b0);
        send_node(KIND_RECT, 1'b1, 15, -15, 1615, 1585, 1'b0);
        send_node(KIND_RECT, 1'b1, 16, 0, 1600, 1600, 1'b0);
        send_node(KIND_RECT, 1'b1, 100, 100, 300, 300, 1'b0);
        send_node(KIND_LINE, 1'b1, 300, 300, 500, 500, 1'b0);
        send_node(KIND_OTHER, 1'b1, -10, 0, 10, 0, 1'b0);
        send_node(KIND_OTHER, 1'b0, 100, 100, 200, 200, 1'b0);
        send_node(KIND_LINE, 1'b1, 5000, 5000, 5001, 5001, 1'b0);
        send_node(KIND_RECT, 1'b0, 0, 0, 1600, 1600, 1'b0);
        send_node(KIND_SPARE, 1'b1, 200, 200, 200, 200, 1'b0);
        send_node(KIND_RECT, 1'b1, 1600, 1600, 0, 0, 1'b0);
        send_node(KIND_OTHER, 1'b1, 0, 0, 0, 0, 1'b1);
        // coordinate extremes and inverted full-range boxes
        send_node(KIND_RECT, 1'b1, CMIN, CMIN, CMAX, CMAX, 1'b0);
        send_node(KIND_RECT, 1'b1, CMAX, CMAX, CMIN, CMIN, 1'b0);
        send_node(KIND_LINE, 1'b1, CMIN, CMIN, CMAX, CMAX, 1'b0);
        send_node(KIND_OTHER, 1'b1, CMAX, CMAX, CMAX, CMAX, 1'b0);
        send_node(KIND_OTHER, 1'b1, CMIN, CMIN, CMIN, CMIN, 1'b1);
        wait_idle();

        write_tolerance(0);
        no_idle = 1'b1;
        while (requests_sent < 90) random_batch($urandom_range(1, 10));
        no_idle = 1'b0;
        wait_idle();

        write_tolerance(255);
        while (requests_sent < 160) random_batch($urandom_range(1, 12));
        // full batch, then two past capacity so the extra nodes are dropped
        random_batch(64);
        wait_idle();
        random_batch(66);
        wait_idle();

        write_tolerance($urandom_range(1, 254));
        while (requests_sent < 330) begin
            no_idle = $urandom_range(0, 3) == 0;
            random_batch($urandom_range(1, 10));
        end
        wait_idle();
        write_tolerance(TOL_RESET);
        random_batch(8);
        wait_idle();

        $display("sent %0d requests in %0d batches, checked %0d group results",
                 requests_sent, batch_count, result_count);
        $display("tolerance settings 16, 0, 255, random; full and overflowing batches");
        if (fail_count == 0) begin
            $display("rect_group_assigner verification clean");
        end else begin
            $display("rect_group_assigner verification failed");
        end
        $finish;
    end

endmodule
